/* design/bot_pkg.sv */
// Package for the branch outcome and target resolver.
// Branch kind codes, field spans and target constants; no dependencies.
`default_nettype none

package bot_pkg;

    typedef enum logic [1:0] {
        KIND_B     = 2'd0,
        KIND_BC    = 2'd1,
        KIND_BCCTR = 2'd2,
        KIND_BCLR  = 2'd3
    } kind_t;

    localparam int unsigned  LI_SPAN      = 26;
    localparam int unsigned  BD_SPAN      = 16;
    localparam logic [31:0]  ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0]  LOW_TWO_MASK = 32'h0000_0003;

endpackage

`default_nettype wire

/* design/branch_outcome_and_target.sv */
// Branch outcome and target resolver: b, bc, bcctr and bclr.
// Depends on bot_pkg for kind codes and constants.
// Each beat passes through an input register and then a result register.
// Throughput: one beat per cycle while m_ready does not stall; the single decode-and-add stage sets this.
// Stalls on m_ready back up through both registers to s_ready.
// Reset (aresetn low, synchronous) empties both stages; payload is not reset.
`default_nettype none

module branch_outcome_and_target (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [31:0] s_instruction_word,
    input  wire logic [31:0] s_pc_address,
    input  wire logic [31:0] s_count_reg,
    input  wire logic [31:0] s_cond_reg,
    input  wire logic [31:0] s_link_reg,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_target,
    output logic             m_is_call,
    output logic             m_is_conditional,
    output logic             m_taken,
    output logic             m_is_register_target
);

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [31:0] word_reg;
    logic [31:0] pc_reg;
    logic [31:0] ctr_reg;
    logic [31:0] cr_reg;
    logic [31:0] lr_reg;

    logic        out_valid_reg;
    logic [31:0] target_reg;
    logic        call_reg;
    logic        cond_reg;
    logic        taken_reg;
    logic        regt_reg;

    logic        out_free;
    logic        in_load;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_load  = s_valid && s_ready;

    // decode
    logic [4:0]  bo;
    logic [4:0]  bi;
    logic        aa;
    logic [31:0] li_ext;
    logic [31:0] bd_ext;
    logic [31:0] rel_base;
    logic [31:0] ctr_dec;
    logic        ctr_ok;
    logic        cr_ok;
    logic        ctr_en;
    logic        cr_en;
    logic [31:0] target_next;
    logic        cond_next;
    logic        taken_next;
    logic        regt_next;

    assign bo = word_reg[25:21];
    assign bi = word_reg[20:16];
    assign aa = word_reg[1];

    assign li_ext = {{(32 - bot_pkg::LI_SPAN){word_reg[bot_pkg::LI_SPAN-1]}},
                     word_reg[bot_pkg::LI_SPAN-1:2], 2'b00};
    assign bd_ext = {{(32 - bot_pkg::BD_SPAN){word_reg[bot_pkg::BD_SPAN-1]}},
                     word_reg[bot_pkg::BD_SPAN-1:2], 2'b00};
    assign rel_base = aa ? 32'd0 : pc_reg;

    assign ctr_dec = ctr_reg - 32'd1;
    assign ctr_ok  = (|ctr_dec) ^ bo[1];
    assign cr_ok   = (cr_reg[5'd31 - bi] == bo[3]);

    always_comb begin
        target_next = bot_pkg::ALL_ONES;
        ctr_en      = 1'b0;
        cr_en       = 1'b0;
        regt_next   = 1'b0;
        unique case (bot_pkg::kind_t'(op_reg))
            bot_pkg::KIND_B: begin
                target_next = li_ext + rel_base;
            end
            bot_pkg::KIND_BC: begin
                target_next = bd_ext + rel_base;
                ctr_en      = !bo[2];
                cr_en       = !bo[4];
            end
            bot_pkg::KIND_BCCTR: begin
                target_next = (ctr_reg != 32'd0) ? (ctr_reg & ~bot_pkg::LOW_TWO_MASK)
                                                 : bot_pkg::ALL_ONES;
                cr_en       = !bo[4];
                regt_next   = 1'b1;
            end
            bot_pkg::KIND_BCLR: begin
                target_next = (lr_reg != 32'd0) ? (lr_reg & ~bot_pkg::LOW_TWO_MASK)
                                                : bot_pkg::ALL_ONES;
                ctr_en      = !bo[2];
                cr_en       = !bo[4];
                regt_next   = 1'b1;
            end
            default: begin
                target_next = bot_pkg::ALL_ONES;
            end
        endcase
    end

    assign cond_next  = ctr_en || cr_en;
    assign taken_next = (!ctr_en || ctr_ok) && (!cr_en || cr_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            op_reg   <= s_opcode;
            word_reg <= s_instruction_word;
            pc_reg   <= s_pc_address;
            ctr_reg  <= s_count_reg;
            cr_reg   <= s_cond_reg;
            lr_reg   <= s_link_reg;
        end
        if (out_free && in_valid_reg) begin
            target_reg <= target_next;
            call_reg   <= word_reg[0];
            cond_reg   <= cond_next;
            taken_reg  <= taken_next;
            regt_reg   <= regt_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_target             = target_reg;
    assign m_is_call            = call_reg;
    assign m_is_conditional     = cond_reg;
    assign m_taken              = taken_reg;
    assign m_is_register_target = regt_reg;

    // checks
    a_stall_backs_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg) |-> !s_ready)
        else $error("input taken while both stages are full and stalled");

    a_beat_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free) |=> out_valid_reg)
        else $error("beat lost between input and result register");

    a_uncond_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free && op_reg == bot_pkg::KIND_B)
        |=> (taken_reg && !cond_reg && !regt_reg))
        else $error("unconditional branch not resolved as taken");

    a_reg_target_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && regt_reg)
        |-> (target_reg[1:0] == 2'b00 || target_reg == bot_pkg::ALL_ONES))
        else $error("register target not word aligned");

endmodule

`default_nettype wire

/* bench/tb_branch_outcome_and_target.sv */
// Testbench for branch_outcome_and_target: directed and random branch beats
// are checked against a local predictor under varied source idle and sink stall.
// Depends on bot_pkg and the branch_outcome_and_target RTL.

module tb_branch_outcome_and_target;

    typedef struct packed {
        bot_pkg::kind_t kind;
        logic [31:0]    word;
        logic [31:0]    pc;
        logic [31:0]    ctr;
        logic [31:0]    cr;
        logic [31:0]    lr;
    } branch_beat_t;

    typedef struct packed {
        logic [31:0] target;
        logic        is_call;
        logic        is_cond;
        logic        taken;
        logic        reg_tgt;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [31:0] s_instruction_word;
    logic [31:0] s_pc_address;
    logic [31:0] s_count_reg;
    logic [31:0] s_cond_reg;
    logic [31:0] s_link_reg;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_target;
    logic        m_is_call;
    logic        m_is_conditional;
    logic        m_taken;
    logic        m_is_register_target;

    branch_beat_t pending_branches[$];
    outcome_t     expected_outcomes[$];
    int           src_idle_pct;
    int           sink_stall_pct;
    int           errors;
    logic         in_beat_taken;

    branch_outcome_and_target dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_instruction_word   (s_instruction_word),
        .s_pc_address         (s_pc_address),
        .s_count_reg          (s_count_reg),
        .s_cond_reg           (s_cond_reg),
        .s_link_reg           (s_link_reg),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_target             (m_target),
        .m_is_call            (m_is_call),
        .m_is_conditional     (m_is_conditional),
        .m_taken              (m_taken),
        .m_is_register_target (m_is_register_target)
    );

    function automatic outcome_t resolve_branch(branch_beat_t b);
        outcome_t    r;
        logic [4:0]  bo;
        logic [4:0]  bi;
        logic        ctr_chk;
        logic        cr_chk;
        logic [31:0] ctr_dec;
        bo        = b.word[25:21];
        bi        = b.word[20:16];
        r         = '0;
        r.is_call = b.word[0];
        r.taken   = 1'b1;
        ctr_chk   = 1'b0;
        cr_chk    = 1'b0;
        case (b.kind)
            bot_pkg::KIND_B: begin
                r.target = {{6{b.word[25]}}, b.word[25:2], 2'b00}
                           + (b.word[1] ? 32'd0 : b.pc);
            end
            bot_pkg::KIND_BC: begin
                ctr_chk  = 1'b1;
                cr_chk   = 1'b1;
                r.target = {{16{b.word[15]}}, b.word[15:2], 2'b00}
                           + (b.word[1] ? 32'd0 : b.pc);
            end
            bot_pkg::KIND_BCCTR: begin
                cr_chk    = 1'b1;
                r.reg_tgt = 1'b1;
                r.target  = (b.ctr != 0) ? (b.ctr & ~bot_pkg::LOW_TWO_MASK)
                                         : bot_pkg::ALL_ONES;
            end
            default: begin
                ctr_chk   = 1'b1;
                cr_chk    = 1'b1;
                r.reg_tgt = 1'b1;
                r.target  = (b.lr != 0) ? (b.lr & ~bot_pkg::LOW_TWO_MASK)
                                        : bot_pkg::ALL_ONES;
            end
        endcase
        if (ctr_chk && !bo[2]) begin
            ctr_dec   = b.ctr - 32'd1;
            r.is_cond = 1'b1;
            if ((ctr_dec != 32'd0) == bo[1])
                r.taken = 1'b0;
        end
        if (cr_chk && !bo[4]) begin
            r.is_cond = 1'b1;
            if (b.cr[31 - bi] != bo[3])
                r.taken = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] bform(logic [4:0] bo, logic [4:0] bi, logic [13:0] bd,
                                          logic aa, logic lk);
        return {6'd16, bo, bi, bd, aa, lk};
    endfunction

    function automatic branch_beat_t mk(bot_pkg::kind_t k, logic [31:0] w, logic [31:0] pc,
                                        logic [31:0] ctr, logic [31:0] cr, logic [31:0] lr);
        branch_beat_t b;
        b.kind = k;
        b.word = w;
        b.pc   = pc;
        b.ctr  = ctr;
        b.cr   = cr;
        b.lr   = lr;
        return b;
    endfunction

    task automatic add_branch(input branch_beat_t b);
        pending_branches = {pending_branches, b};
    endtask

    // register values near zero matter most: 0, 1 and 0..3 hit the edge cases
    function automatic logic [31:0] pick_reg();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic branch_beat_t random_branch();
        return mk(bot_pkg::kind_t'($urandom_range(3)), $urandom, $urandom,
                  pick_reg(), $urandom, pick_reg());
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin : drive_in
        branch_beat_t b;
        if (aresetn && (!s_valid || in_beat_taken)) begin
            if (pending_branches.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                b = pending_branches.pop_front();
                s_valid            <= 1'b1;
                s_opcode           <= b.kind;
                s_instruction_word <= b.word;
                s_pc_address       <= b.pc;
                s_count_reg        <= b.ctr;
                s_cond_reg         <= b.cr;
                s_link_reg         <= b.lr;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : watch
        outcome_t want;
        if (!aresetn) begin
            in_beat_taken <= 1'b0;
        end else begin
            in_beat_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                expected_outcomes = {expected_outcomes,
                    resolve_branch(mk(bot_pkg::kind_t'(s_opcode), s_instruction_word,
                                      s_pc_address, s_count_reg, s_cond_reg, s_link_reg))};
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result beat: target %h", m_target);
                    errors++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_target !== want.target) begin
                        $error("target: expected %h, got %h", want.target, m_target);
                        errors++;
                    end
                    if (m_is_call !== want.is_call) begin
                        $error("is_call: expected %b, got %b", want.is_call, m_is_call);
                        errors++;
                    end
                    if (m_is_conditional !== want.is_cond) begin
                        $error("is_conditional: expected %b, got %b",
                               want.is_cond, m_is_conditional);
                        errors++;
                    end
                    if (m_taken !== want.taken) begin
                        $error("taken: expected %b, got %b", want.taken, m_taken);
                        errors++;
                    end
                    if (m_is_register_target !== want.reg_tgt) begin
                        $error("is_register_target: expected %b, got %b",
                               want.reg_tgt, m_is_register_target);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase_idle[4];
        int phase_stall[4];
        errors             = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_opcode           = '0;
        s_instruction_word = '0;
        s_pc_address       = '0;
        s_count_reg        = '0;
        s_cond_reg         = '0;
        s_link_reg         = '0;
        m_ready            = 1'b0;
        in_beat_taken      = 1'b0;
        phase_idle  = '{0, 47, 0, 24};
        phase_stall = '{0, 0, 47, 24};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // displacement extremes, AA/LK, address wrap
        add_branch(mk(bot_pkg::KIND_B, {6'd18, 24'h7FFFFF, 2'b00}, 0, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_B, {6'd18, 24'h800000, 2'b01}, 32'h10, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_B, {6'd18, 24'hFFFFFF, 2'b11}, '1, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_B, {6'd18, 24'h000001, 2'b00}, 32'hFFFFFFFC,
                      0, 0, 0));
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b10100, 0, 14'h1FFF, 0, 0),
                      32'h1000, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b10100, 0, 14'h2000, 1, 1),
                      32'h1000, 0, 0, 0));
        // CTR test with CTR-1 reaching zero and wrapping from zero
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b00000, 0, 14'h4, 0, 0), 0, 1, 0, 0));
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b00010, 31, 14'h4, 0, 0), 0, 1, 0, 0));
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b10000, 0, 14'h8, 0, 0), 0, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b10010, 0, 14'h8, 0, 0), 0, 0, 0, 0));
        // CR bit for BI = 0 (register bit 31) both set and clear
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b01100, 0, 14'h3, 0, 0), 0, 5,
                      32'h80000000, 0));
        add_branch(mk(bot_pkg::KIND_BC, bform(5'b01100, 0, 14'h3, 0, 0), 0, 5,
                      32'h7FFFFFFF, 0));
        // register targets: zero gives all ones, 1..3 gives zero
        add_branch(mk(bot_pkg::KIND_BCCTR, bform(5'b10100, 0, 0, 0, 0), 0, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_BCCTR, bform(5'b10100, 0, 0, 1, 0), 0, 3, 0, 0));
        add_branch(mk(bot_pkg::KIND_BCCTR, bform(5'b00000, 31, 0, 0, 0), 0, '1, 1, 0));
        add_branch(mk(bot_pkg::KIND_BCCTR, bform(5'b01100, 31, 0, 0, 1), 0, 1, 1, 0));
        add_branch(mk(bot_pkg::KIND_BCLR, bform(5'b10100, 0, 0, 0, 0), 0, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_BCLR, bform(5'b10000, 0, 0, 0, 0), 0, 2, 0, 2));
        add_branch(mk(bot_pkg::KIND_BCLR, bform(5'b00010, 15, 0, 0, 1), 0, 1, 0, '1));
        add_branch(mk(bot_pkg::KIND_BCLR, bform(5'b11111, 0, 0, 1, 0), '1, 0, 0,
                      32'h12345677));
        // all-ones and all-zero words, unused bits set
        add_branch(mk(bot_pkg::KIND_B, '1, 0, 0, 0, 0));
        add_branch(mk(bot_pkg::KIND_BC, '1, 32'h100, '1, '1, '1));
        add_branch(mk(bot_pkg::KIND_BCCTR, 0, 0, 4, 0, 0));
        add_branch(mk(bot_pkg::KIND_BCLR, 0, 0, 0, 0, 4));

        for (int p = 0; p < 4; p++) begin
            while (pending_branches.size() != 0) @(posedge aclk);
            src_idle_pct   = phase_idle[p];
            sink_stall_pct = phase_stall[p];
            for (int i = 0; i < 150; i++)
                add_branch(random_branch());
        end

        while (pending_branches.size() != 0 || s_valid) @(posedge aclk);
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
